FILE: hdl/tefp_pkg.sv
// ----------------------------------------------------------------------------
// Touch event frame parser package
// Shared types, frame constants and sequencer state encodings.
// ----------------------------------------------------------------------------
package tefp_pkg;

   localparam int FRAME_LEN = 7;
   localparam int CNT_W = $clog2(FRAME_LEN + 1);
   localparam int EVENT_QUEUE_DEPTH_DEF = 8;

   localparam logic [7:0] FRAME_HEADER = 8'h65;
   localparam logic [7:0] TRAILER_BYTE = 8'hFF;

   localparam logic FUNC_RX_BYTE = 1'b0;
   localparam logic FUNC_POP     = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       event_valid;
      logic [7:0] page_id;
      logic [7:0] comp_id;
      logic [7:0] event_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0] page_id;
      logic [7:0] comp_id;
      logic [7:0] event_code;
   } event_type;

   typedef struct packed {
      logic      valid;
      event_type evt;
   } scan_push_type;

   typedef enum logic {
      SCAN_IDLE,
      SCAN_RUN
   } scan_state_type;

   typedef enum logic [1:0] {
      Q_IDLE,
      Q_EMIT
   } queue_state_type;

endpackage

FILE: hdl/touch_event_frame_parser.sv
// ----------------------------------------------------------------------------
// Touch event frame parser
// Parses 65 pp cc ee FF FF FF frames from received bytes into an event queue
// and returns the oldest queued event on a pop request.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_      in         req_valid/stall    req_type  (func, rx_byte)
//  rsp_      out        rsp_valid/stall    rsp_type  (event_valid, ids, code)
//
//  A received byte is appended to the window, then the scanner resolves it
//  one compare step per cycle, up to eight steps on a resync. A pop is a
//  registered read of the event memory, then a load of the output register
//  once it is free. req_stall is high while either part is working.
//  A stalled result holds in the output register; bytes are still taken
//  unless a pop waits on it. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module touch_event_frame_parser
   import tefp_pkg::*;
#(
   parameter int EVENT_QUEUE_DEPTH = EVENT_QUEUE_DEPTH_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic          req_xfer;
   logic          scan_busy;
   logic          queue_busy;
   scan_push_type push;

   assign req_stall = scan_busy || queue_busy;
   assign req_xfer  = req_valid && !req_stall;

   tefp_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (req_xfer && (req_payload.func == FUNC_RX_BYTE)),
      .rx_byte (req_payload.rx_byte),
      .busy    (scan_busy),
      .push    (push)
   );

   tefp_queue #(
      .EVENT_QUEUE_DEPTH (EVENT_QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .pop_start   (req_xfer && (req_payload.func == FUNC_POP)),
      .busy        (queue_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: hdl/tefp_scan.sv
// ----------------------------------------------------------------------------
// Frame window scanner
// Holds up to seven received bytes and resolves them one compare step per
// cycle: drop a non-header byte, wait on a short frame, or check the trailer.
// ----------------------------------------------------------------------------
module tefp_scan
   import tefp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [7:0]    rx_byte,
   output logic          busy,
   output scan_push_type push
);

   scan_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       win_ff [FRAME_LEN];
   logic [7:0]       win_in [FRAME_LEN];

   logic is_hdr;
   logic is_full;
   logic trailer_ok;

   assign is_hdr     = (win_ff[0] == FRAME_HEADER);
   assign is_full    = (count_ff == CNT_W'(FRAME_LEN));
   assign trailer_ok = (win_ff[4] == TRAILER_BYTE) && (win_ff[5] == TRAILER_BYTE) &&
                       (win_ff[6] == TRAILER_BYTE);
   assign busy       = (state_ff != SCAN_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SCAN_IDLE: begin
            if (start) state_in = SCAN_RUN;
         end
         SCAN_RUN: begin
            if (count_ff == '0) begin
               state_in = SCAN_IDLE;
            end else if (is_hdr && (!is_full || trailer_ok)) begin
               state_in = SCAN_IDLE;
            end
         end
         default: state_in = SCAN_IDLE;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      win_in     = win_ff;
      push.valid = 1'b0;
      push.evt   = '{page_id: win_ff[1], comp_id: win_ff[2], event_code: win_ff[3]};
      unique case (state_ff)
         SCAN_IDLE: begin
            if (start) begin
               win_in[count_ff] = rx_byte;
               count_in         = count_ff + 1'b1;
            end
         end
         SCAN_RUN: begin
            if (count_ff != '0) begin
               if (!is_hdr || (is_full && !trailer_ok)) begin
                  for (int i = 0; i < FRAME_LEN - 1; i++) begin
                     win_in[i] = win_ff[i + 1];
                  end
                  count_in = count_ff - 1'b1;
               end else if (is_full) begin
                  push.valid = 1'b1;
                  count_in   = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   // Between bytes the window is either empty or a partial frame behind a header.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN_IDLE) |-> (count_ff < CNT_W'(FRAME_LEN)))
      else $error("scan idle with a full window");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == SCAN_IDLE && count_ff != '0) |-> is_hdr)
      else $error("held window does not start with a header");

   assert property (@(posedge clock) disable iff (reset)
      push.valid |=> (count_ff == '0 && state_ff == SCAN_IDLE))
      else $error("window not cleared after an event push");

endmodule

FILE: hdl/tefp_queue.sv
// ----------------------------------------------------------------------------
// Touch event queue
// Circular event memory with one slot kept free, a registered read port and
// the result output register.
// ----------------------------------------------------------------------------
module tefp_queue
   import tefp_pkg::*;
#(
   parameter int EVENT_QUEUE_DEPTH = EVENT_QUEUE_DEPTH_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  scan_push_type push,
   input  logic          pop_start,
   output logic          busy,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_payload
);

   localparam int PTR_W = $clog2(EVENT_QUEUE_DEPTH);

   queue_state_type  state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic             hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   event_type        mem [EVENT_QUEUE_DEPTH];
   event_type        rd_data_ff;

   logic empty;
   logic full;
   logic wr_en;
   logic rd_en;
   logic load;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(EVENT_QUEUE_DEPTH - 1)) return '0;
      return p + 1'b1;
   endfunction

   assign empty = (head_ff == tail_ff);
   assign full  = (ptr_next(head_ff) == tail_ff);
   assign wr_en = push.valid && !full;
   assign busy  = (state_ff != Q_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         Q_IDLE: if (pop_start) state_in = Q_EMIT;
         Q_EMIT: if (!rsp_valid_ff || !rsp_stall) state_in = Q_IDLE;
         default: state_in = Q_IDLE;
      endcase
   end

   always_comb begin
      head_in = wr_en ? ptr_next(head_ff) : head_ff;
      tail_in = tail_ff;
      hit_in  = hit_ff;
      rd_en   = 1'b0;
      load    = 1'b0;
      unique case (state_ff)
         Q_IDLE: begin
            if (pop_start) begin
               hit_in = !empty;
               rd_en  = !empty;
               if (!empty) tail_in = ptr_next(tail_ff);
            end
         end
         Q_EMIT: load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   // An empty pop reports all-zero fields.
   always_comb begin
      rsp_in.event_valid = hit_ff;
      rsp_in.page_id     = hit_ff ? rd_data_ff.page_id : 8'h00;
      rsp_in.comp_id     = hit_ff ? rd_data_ff.comp_id : 8'h00;
      rsp_in.event_code  = hit_ff ? rd_data_ff.event_code : 8'h00;
      rsp_valid_in       = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= Q_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[head_ff] <= push.evt;
      if (rd_en) rd_data_ff <= mem[tail_ff];
      if (load) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      !(push.valid && state_ff != Q_IDLE))
      else $error("event push while a pop is in progress");

   assert property (@(posedge clock) disable iff (reset)
      (head_ff <= PTR_W'(EVENT_QUEUE_DEPTH - 1)) && (tail_ff <= PTR_W'(EVENT_QUEUE_DEPTH - 1)))
      else $error("queue pointer beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == Q_EMIT))
      else $error("result appeared without a pop");

endmodule
